// ===== hw/rtl/dali_pkg.sv =====
// Shared types and constants for the DALI master transceiver.
package dali_pkg;

    localparam int FORWARD_BITS = 16;
    localparam int REPLY_BITS   = 8;
    localparam int TICKS_PER_TE = 2;

    localparam int HALF_TOTAL = 2 + 2 * FORWARD_BITS + 4;
    localparam int HBI_W      = $clog2(HALF_TOTAL + 1);
    localparam int FBIT_W     = $clog2(FORWARD_BITS);
    localparam int SUB_W      = (TICKS_PER_TE > 2) ? $clog2(TICKS_PER_TE) : 1;
    localparam int RCNT_W     = $clog2(REPLY_BITS + 1);
    localparam int WAIT_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 8;

    localparam int START_WAIT = (3 * TICKS_PER_TE) / 2;
    localparam int BIT_WAIT   = 2 * TICKS_PER_TE;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_REPLY_WAIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPLY_WAIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_WAIT       = 2'd3;

    localparam logic [CFG_W-1:0] RST_TICKS_PER_MS   = 8'd5;
    localparam logic [CFG_W-1:0] RST_MIN_REPLY_WAIT = 8'd7;
    localparam logic [CFG_W-1:0] RST_MAX_REPLY_WAIT = 8'd22;
    localparam logic [CFG_W-1:0] RST_END_WAIT       = 8'd22;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SEND   = 3'd1,
        PH_DELAY  = 3'd2,
        PH_RMIN   = 3'd3,
        PH_WINDOW = 3'd4,
        PH_START  = 3'd5,
        PH_RECV   = 3'd6,
        PH_END    = 3'd7
    } t_phase;

endpackage

// ===== hw/rtl/dali_master_transceiver.sv =====
// DALI bus master: Manchester forward frame, echo checks and backward frame receive.
//
// Each input word is either a tick (one half of Te, carrying the sampled receive
// line) or a command start. All bus timing is counted in ticks, so the word rate
// sets the bus timing. Every accepted word yields exactly one result word with the
// transmit level, busy, done, collision flag and reply byte after that word. The
// block takes one word per clock: the whole state update is combinational and its result
// is registered into the state and the output register together; a new word is accepted
// whenever the output register is empty or being drained. A command sent while busy is
// ignored; ticks while idle have no effect. Configuration registers are written through
// the plain write port and should only change while the block is idle.
module dali_master_transceiver (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // line_active, address_byte[8:1], data_byte[16:9], send_twice, expect_reply,
    // repeat_delay_ms[26:19], zero fill
    input  logic [dali_pkg::IN_DATA_W-1:0]          s_axis_tdata,
    // opcode
    input  logic [dali_pkg::IN_USER_W-1:0]          s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // drive_level, busy_res, done_res, collision_error, reply_byte[11:4], zero fill
    output logic [dali_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    input  logic                                    i_cfg_we,
    input  logic [dali_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [dali_pkg::CFG_W-1:0]              i_cfg_data
);

    // configuration
    logic [dali_pkg::CFG_W-1:0] r_ticks_per_ms, r_min_wait, r_max_wait, r_end_wait;

    // command state
    dali_pkg::t_phase                  r_phase, n_phase;
    logic [dali_pkg::HBI_W-1:0]        r_hbi, n_hbi;
    logic [dali_pkg::SUB_W-1:0]        r_sub, n_sub;
    logic [dali_pkg::WAIT_W-1:0]       r_wait, n_wait;
    logic [dali_pkg::FORWARD_BITS-1:0] r_frame, n_frame;
    logic [dali_pkg::REPLY_BITS-1:0]   r_reply, n_reply;
    logic [dali_pkg::RCNT_W-1:0]       r_rcnt, n_rcnt;
    logic                              r_err, n_err;
    logic                              r_rep, n_rep;
    logic                              r_want, n_want;
    logic [dali_pkg::CFG_W-1:0]        r_delay, n_delay;
    logic                              r_line_out, n_line_out;

    // result register
    logic                              r_out_valid;
    logic [dali_pkg::OUT_DATA_W-1:0]   r_out_data, n_out_data;

    // unpacked input word
    logic                              in_op, in_line, in_twice, in_reply;
    logic [7:0]                        in_addr, in_data, in_delay;
    logic                              fire;

    // helper values
    logic [dali_pkg::WAIT_W-1:0]       delay_wc, end_wc, rmin_wc, win_wc, wait_dec;
    logic [dali_pkg::HBI_W-1:0]        hbi_inc, hbi_m2;
    logic [dali_pkg::FBIT_W-1:0]       bit_sel;
    logic                              frame_bit, wait_zero, done;
    logic                              go_start, go_rmin, go_window, go_end;

    assign in_op    = s_axis_tuser[0];
    assign in_line  = s_axis_tdata[0];
    assign in_addr  = s_axis_tdata[8:1];
    assign in_data  = s_axis_tdata[16:9];
    assign in_twice = s_axis_tdata[17];
    assign in_reply = s_axis_tdata[18];
    assign in_delay = s_axis_tdata[26:19];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign delay_wc = dali_pkg::WAIT_W'(r_delay) * dali_pkg::WAIT_W'(r_ticks_per_ms);
    assign end_wc   = dali_pkg::WAIT_W'(r_end_wait) * dali_pkg::WAIT_W'(dali_pkg::TICKS_PER_TE);
    assign rmin_wc  = dali_pkg::WAIT_W'(r_min_wait) * dali_pkg::WAIT_W'(dali_pkg::TICKS_PER_TE);
    assign win_wc   = (r_max_wait > r_min_wait)
                    ? dali_pkg::WAIT_W'(r_max_wait - r_min_wait)
                      * dali_pkg::WAIT_W'(dali_pkg::TICKS_PER_TE)
                    : '0;
    assign wait_dec  = (r_wait != '0) ? r_wait - 1'b1 : '0;
    assign wait_zero = (wait_dec == '0);

    // data half-bit: bit index counts from the MSB, first half is inverted
    assign hbi_inc   = r_hbi + 1'b1;
    assign hbi_m2    = hbi_inc - dali_pkg::HBI_W'(2);
    assign bit_sel   = dali_pkg::FBIT_W'(dali_pkg::FORWARD_BITS - 1)
                     - hbi_m2[dali_pkg::FBIT_W:1];
    assign frame_bit = r_frame[bit_sel];

    always_comb begin
        n_phase    = r_phase;
        n_hbi      = r_hbi;
        n_sub      = r_sub;
        n_wait     = r_wait;
        n_frame    = r_frame;
        n_reply    = r_reply;
        n_rcnt     = r_rcnt;
        n_err      = r_err;
        n_rep      = r_rep;
        n_want     = r_want;
        n_delay    = r_delay;
        n_line_out = r_line_out;
        done       = 1'b0;
        go_start   = 1'b0;
        go_rmin    = 1'b0;
        go_window  = 1'b0;
        go_end     = 1'b0;

        if (in_op == dali_pkg::OP_START) begin
            if (r_phase == dali_pkg::PH_IDLE) begin
                n_frame  = {in_addr, in_data};
                n_rep    = in_twice;
                n_want   = in_reply;
                n_delay  = in_delay;
                n_err    = 1'b0;
                n_reply  = '0;
                n_rcnt   = '0;
                go_start = 1'b1;
            end
        end else begin
            case (r_phase)
                dali_pkg::PH_SEND: begin
                    if (r_sub == dali_pkg::SUB_W'(dali_pkg::TICKS_PER_TE - 1)) begin
                        n_sub = '0;
                        n_hbi = hbi_inc;
                        if (hbi_inc == dali_pkg::HBI_W'(1)) begin
                            // second start half: line must be seen active
                            if (!in_line) n_err = 1'b1;
                            n_line_out = 1'b1;
                        end else if (hbi_inc < dali_pkg::HBI_W'(2 + 2 * dali_pkg::FORWARD_BITS)) begin
                            n_line_out = hbi_inc[0] ? frame_bit : ~frame_bit;
                        end else if (hbi_inc < dali_pkg::HBI_W'(dali_pkg::HALF_TOTAL)) begin
                            n_line_out = 1'b1;
                        end else begin
                            n_line_out = 1'b1;
                            if (in_line) n_err = 1'b1;
                            if (r_rep) begin
                                n_rep  = 1'b0;
                                n_wait = delay_wc;
                                if (delay_wc == '0) go_start = 1'b1;
                                else n_phase = dali_pkg::PH_DELAY;
                            end else if (r_want) begin
                                go_rmin = 1'b1;
                            end else begin
                                go_end = 1'b1;
                            end
                        end
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
                dali_pkg::PH_DELAY: begin
                    n_wait = wait_dec;
                    if (wait_zero) go_start = 1'b1;
                end
                dali_pkg::PH_RMIN: begin
                    n_wait = wait_dec;
                    if (wait_zero) go_window = 1'b1;
                end
                dali_pkg::PH_WINDOW: begin
                    if (in_line) begin
                        n_phase = dali_pkg::PH_START;
                        n_wait  = dali_pkg::WAIT_W'(dali_pkg::START_WAIT);
                    end else begin
                        n_wait = wait_dec;
                        if (wait_zero) begin
                            n_reply = '0;
                            go_end  = 1'b1;
                        end
                    end
                end
                dali_pkg::PH_START: begin
                    n_wait = wait_dec;
                    if (wait_zero) begin
                        n_reply = '0;
                        if (!in_line) begin
                            n_phase = dali_pkg::PH_RECV;
                            n_rcnt  = '0;
                            n_wait  = dali_pkg::WAIT_W'(dali_pkg::BIT_WAIT);
                        end else begin
                            go_end = 1'b1;
                        end
                    end
                end
                dali_pkg::PH_RECV: begin
                    n_wait = wait_dec;
                    if (wait_zero) begin
                        n_reply = {r_reply[dali_pkg::REPLY_BITS-2:0], ~in_line};
                        n_rcnt  = r_rcnt + 1'b1;
                        if (n_rcnt >= dali_pkg::RCNT_W'(dali_pkg::REPLY_BITS)) go_end = 1'b1;
                        else n_wait = dali_pkg::WAIT_W'(dali_pkg::BIT_WAIT);
                    end
                end
                dali_pkg::PH_END: begin
                    n_wait = wait_dec;
                    if (wait_zero) begin
                        n_phase = dali_pkg::PH_IDLE;
                        done    = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // zero-length waits fall through to the next phase within this word
        if (go_start) begin
            n_phase    = dali_pkg::PH_SEND;
            n_hbi      = '0;
            n_sub      = '0;
            n_line_out = 1'b0;
            if (in_line) n_err = 1'b1;
        end
        if (go_rmin) begin
            n_wait = rmin_wc;
            if (rmin_wc == '0) go_window = 1'b1;
            else n_phase = dali_pkg::PH_RMIN;
        end
        if (go_window) begin
            n_wait = win_wc;
            if (win_wc == '0) begin
                n_reply = '0;
                go_end  = 1'b1;
            end else begin
                n_phase = dali_pkg::PH_WINDOW;
            end
        end
        if (go_end) begin
            n_wait = end_wc;
            if (end_wc == '0) begin
                n_phase = dali_pkg::PH_IDLE;
                done    = 1'b1;
            end else begin
                n_phase = dali_pkg::PH_END;
            end
        end

        n_out_data = {4'b0, n_reply[7:0], n_err, done,
                      (n_phase != dali_pkg::PH_IDLE), n_line_out};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_ms <= dali_pkg::RST_TICKS_PER_MS;
            r_min_wait     <= dali_pkg::RST_MIN_REPLY_WAIT;
            r_max_wait     <= dali_pkg::RST_MAX_REPLY_WAIT;
            r_end_wait     <= dali_pkg::RST_END_WAIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dali_pkg::CFG_TICKS_PER_MS:   r_ticks_per_ms <= i_cfg_data;
                dali_pkg::CFG_MIN_REPLY_WAIT: r_min_wait     <= i_cfg_data;
                dali_pkg::CFG_MAX_REPLY_WAIT: r_max_wait     <= i_cfg_data;
                dali_pkg::CFG_END_WAIT:       r_end_wait     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= dali_pkg::PH_IDLE;
            r_hbi      <= '0;
            r_sub      <= '0;
            r_wait     <= '0;
            r_reply    <= '0;
            r_rcnt     <= '0;
            r_err      <= 1'b0;
            r_rep      <= 1'b0;
            r_want     <= 1'b0;
            r_line_out <= 1'b1;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_hbi      <= n_hbi;
            r_sub      <= n_sub;
            r_wait     <= n_wait;
            r_reply    <= n_reply;
            r_rcnt     <= n_rcnt;
            r_err      <= n_err;
            r_rep      <= n_rep;
            r_want     <= n_want;
            r_line_out <= n_line_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_frame <= n_frame;
            r_delay <= n_delay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) r_out_data <= n_out_data;
    end

    // every accepted word leaves a result word behind
    a_fire_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> m_axis_tvalid)
        else $error("accepted word produced no result");

    // a completing word reports the block as no longer busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> !m_axis_tdata[1])
        else $error("done reported while busy");

    // bus is released whenever no command runs
    a_idle_line_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dali_pkg::PH_IDLE) |-> r_line_out)
        else $error("transmit line driven while idle");

    // half-bit counter stays inside the frame while sending
    a_send_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dali_pkg::PH_SEND) |-> (r_hbi < dali_pkg::HBI_W'(dali_pkg::HALF_TOTAL)))
        else $error("half-bit index past end of frame");

    // reply bit counter never reaches the full count while still receiving
    a_recv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dali_pkg::PH_RECV)
        |-> (r_rcnt < dali_pkg::RCNT_W'(dali_pkg::REPLY_BITS)))
        else $error("reply bit count overran");

endmodule
